>>> hw/rtl/swm_pkg.sv
// Shared types, constants and functions for the swerve module kinematics block.
// Used by swm_ctrl, swm_dp, swerve_module_kinematics and tb_top; depends on nothing else.
package swm_pkg;

   localparam int MODULE_COUNT      = 4;
   localparam int MOD_W             = 2;
   localparam int VECTOR_ITERATIONS = 16;
   localparam int ITER_W            = $clog2(VECTOR_ITERATIONS);
   localparam int ATAN_ENTRIES      = 24;

   // Datapath widths.
   localparam int CSR_W   = 14;
   localparam int VEL_W   = 16;
   localparam int ANG_W   = 15;
   localparam int OFF_W   = 18;
   localparam int VEC_W   = 19;
   localparam int XY_W    = 28;
   localparam int Z_W     = 24;
   localparam int MAG_W   = 20;
   localparam int OUT_W   = 16;
   localparam int SAT_W   = 22;
   localparam int REQ_W   = 112;
   localparam int RSP_W   = 128;

   // Angle constants, 1/64 degree and 1/4096 degree.
   localparam int FULL_TURN    = 23040;
   localparam int HALF_TURN    = 11520;
   localparam int QUARTER_TURN = 5760;
   localparam int Z_FULL       = 1474560;
   localparam int Z_HALF       = 737280;
   localparam int INV_GAIN_Q16 = 39797;

   // Opcodes. The spare code behaves as stop.
   localparam logic [1:0] OP_STOP   = 2'd0;
   localparam logic [1:0] OP_REMOTE = 2'd1;
   localparam logic [1:0] OP_DRIVE  = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_MOUNT_SINE     = 2'd0;
   localparam logic [1:0] REG_MOUNT_COSINE   = 2'd1;
   localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              off_x;
      logic              off_y;
      logic              load_vec;
      logic              iter;
      logic [ITER_W-1:0] iter_idx;
      logic              scale;
      logic              finish;
      logic [MOD_W-1:0]  mod_idx;
      logic              publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bypass;
      logic out_free;
   } status_type;

   // Arctangent of 2^-i in 1/4096 degree.
   function automatic logic signed [Z_W-1:0] atan_lookup(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = 24'sd184320;
         5'd1:    v = 24'sd108810;
         5'd2:    v = 24'sd57492;
         5'd3:    v = 24'sd29184;
         5'd4:    v = 24'sd14649;
         5'd5:    v = 24'sd7331;
         5'd6:    v = 24'sd3667;
         5'd7:    v = 24'sd1833;
         5'd8:    v = 24'sd917;
         5'd9:    v = 24'sd458;
         5'd10:   v = 24'sd229;
         5'd11:   v = 24'sd115;
         5'd12:   v = 24'sd57;
         5'd13:   v = 24'sd29;
         5'd14:   v = 24'sd14;
         5'd15:   v = 24'sd7;
         5'd16:   v = 24'sd4;
         5'd17:   v = 24'sd2;
         5'd18:   v = 24'sd1;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

   // Saturate a signed value to 16 bits.
   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 22'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/swerve_module_kinematics.sv
// Swerve drive inverse kinematics for four modules: controller swm_ctrl plus datapath swm_dp.
// Sequence for a driving command: capture of the accepted beat, x offset, y offset, then per
// module load, the vectoring steps, scale and finish, then publish of the result beat;
// stop, hold and zero-vector modules skip the vectoring steps and the scale.
// A new item is taken only after the last result is published, as the single shared vectoring unit serves one item.
// Reset (synchronous, active high) restores register defaults and clears the angle state.
module swerve_module_kinematics (
   input  logic                             clock,
   input  logic                             reset,
   // opcode[1:0], vel_x[17:2], vel_y[33:18], vel_w[49:34], fb_angle_0[64:50],
   // fb_angle_1[79:65], fb_angle_2[94:80], fb_angle_3[109:95], zero fill
   input  logic [swm_pkg::REQ_W-1:0]        req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // drive_speed_0..3 [63:0], steer_target_0..3 [127:64], 16 bits each
   output logic [swm_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_index,
   input  logic [swm_pkg::CSR_W-1:0]        csr_wdata
);

   swm_pkg::cmd_type    cmd;
   swm_pkg::status_type status;

   swm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // After an accepted beat the block is busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock) reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // A result is published only from the done state, never while taking input.
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !req_tready)
      else $error("result published while accepting input");

endmodule

>>> hw/rtl/swm_ctrl.sv
// Sequencing state machine for the swerve module kinematics block.
// Depends on swm_pkg; drives the datapath swm_dp through cmd_type commands.
module swm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  swm_pkg::status_type status,
   output swm_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_OFFX  = 8'b0000_0010,
      S_OFFY  = 8'b0000_0100,
      S_LOAD  = 8'b0000_1000,
      S_ITER  = 8'b0001_0000,
      S_SCALE = 8'b0010_0000,
      S_FIN   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   localparam logic [swm_pkg::ITER_W-1:0] ITER_LAST =
      swm_pkg::ITER_W'(swm_pkg::VECTOR_ITERATIONS - 1);
   localparam logic [swm_pkg::MOD_W-1:0] MOD_LAST =
      swm_pkg::MOD_W'(swm_pkg::MODULE_COUNT - 1);

   state_type                     state_ff, state_in;
   logic [swm_pkg::MOD_W-1:0]     mod_ff, mod_in;
   logic [swm_pkg::ITER_W-1:0]    iter_ff, iter_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      iter_in      = iter_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.mod_idx  = mod_ff;
      cmd.iter_idx = iter_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_OFFX;
            end
         end
         S_OFFX: begin
            cmd.off_x = 1'b1;
            state_in  = S_OFFY;
         end
         S_OFFY: begin
            cmd.off_y = 1'b1;
            mod_in    = '0;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_vec = 1'b1;
            iter_in      = '0;
            state_in     = status.bypass ? S_FIN : S_ITER;
         end
         S_ITER: begin
            cmd.iter = 1'b1;
            iter_in  = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            if (mod_ff == MOD_LAST) begin
               state_in = S_DONE;
            end else begin
               mod_in   = mod_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mod_ff   <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

>>> hw/rtl/swm_dp.sv
// Datapath of the swerve module kinematics block: item registers, offset multiplier,
// shared vectoring unit, angle and speed finishing, state and result registers. Uses swm_pkg.
module swm_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  swm_pkg::cmd_type                   cmd,
   output swm_pkg::status_type                status,
   input  logic [swm_pkg::REQ_W-1:0]          req_tdata,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_index,
   input  logic [swm_pkg::CSR_W-1:0]          csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swm_pkg::RSP_W-1:0]          rsp_tdata
);

   localparam int N = swm_pkg::MODULE_COUNT;

   // Configuration registers.
   logic [swm_pkg::CSR_W-1:0] sine_ff, cosine_ff, thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_ff   <= 14'd5793;
         cosine_ff <= 14'd5793;
         thr_ff    <= 14'd819;
      end else if (csr_wr_en) begin
         case (csr_index)
            swm_pkg::REG_MOUNT_SINE:     sine_ff   <= csr_wdata;
            swm_pkg::REG_MOUNT_COSINE:   cosine_ff <= csr_wdata;
            swm_pkg::REG_HOLD_THRESHOLD: thr_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item registers, captured on the accepted beat.
   logic [1:0]                       op_ff;
   logic signed [swm_pkg::VEL_W-1:0] vx_ff, vy_ff, vw_ff;
   logic [swm_pkg::ANG_W-1:0]        fb_ff [N];
   logic                             hold_ff;

   logic signed [swm_pkg::VEL_W-1:0] in_vx, in_vy, in_vw;
   logic [16:0]                      abs_x, abs_y, abs_w;
   logic                             in_hold;

   assign in_vx = req_tdata[17:2];
   assign in_vy = req_tdata[33:18];
   assign in_vw = req_tdata[49:34];

   // Hold window test on the incoming beat.
   always_comb begin
      abs_x   = in_vx[15] ? 17'(-{in_vx[15], in_vx}) : {1'b0, in_vx};
      abs_y   = in_vy[15] ? 17'(-{in_vy[15], in_vy}) : {1'b0, in_vy};
      abs_w   = in_vw[15] ? 17'(-{in_vw[15], in_vw}) : {1'b0, in_vw};
      in_hold = (req_tdata[1:0] == swm_pkg::OP_REMOTE) &&
                (abs_x < {3'b0, thr_ff}) && (abs_y < {3'b0, thr_ff}) &&
                (abs_w < {3'b0, thr_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tdata[1:0];
         vx_ff    <= in_vx;
         vy_ff    <= in_vy;
         vw_ff    <= in_vw;
         fb_ff[0] <= req_tdata[64:50];
         fb_ff[1] <= req_tdata[79:65];
         fb_ff[2] <= req_tdata[94:80];
         fb_ff[3] <= req_tdata[109:95];
         hold_ff  <= in_hold;
      end
   end

   // Mounting offsets: one shared multiplier, x offset then y offset.
   logic signed [swm_pkg::OFF_W-1:0] ox_ff, oy_ff;
   logic signed [14:0]               off_coef;
   logic signed [30:0]               off_prod;
   logic signed [31:0]               off_rnd;

   always_comb begin
      off_coef = signed'({1'b0, cmd.off_x ? sine_ff : cosine_ff});
      off_prod = vw_ff * off_coef;
      off_rnd  = 32'(off_prod) + 32'sd4096;
   end

   always_ff @(posedge clock) begin
      if (cmd.off_x) begin
         ox_ff <= off_rnd[30:13];
      end
      if (cmd.off_y) begin
         oy_ff <= off_rnd[30:13];
      end
   end

   // Per-module velocity vector and bypass decision.
   logic signed [swm_pkg::VEC_W-1:0] sx, sy, vec_x, vec_y;
   logic                             drive_op, zero_vec, bypass;

   always_comb begin
      sx = (cmd.mod_idx == 2'd0 || cmd.mod_idx == 2'd1) ? 19'(ox_ff) : -19'(ox_ff);
      sy = (cmd.mod_idx == 2'd0 || cmd.mod_idx == 2'd3) ? 19'(oy_ff) : -19'(oy_ff);
      vec_x    = 19'(vx_ff) + sx;
      vec_y    = 19'(vy_ff) + sy;
      drive_op = (op_ff == swm_pkg::OP_REMOTE) || (op_ff == swm_pkg::OP_DRIVE);
      zero_vec = (vec_x == '0) && (vec_y == '0);
      bypass   = hold_ff || !drive_op || zero_vec;
   end

   // Vectoring unit: x, y, z registers and one micro rotation per cycle.
   logic signed [swm_pkg::XY_W-1:0]  x_ff, y_ff, xi, yi, dx, dy;
   logic signed [swm_pkg::Z_W-1:0]   z_ff, atan_v;
   logic                             byp_ff;
   logic [swm_pkg::ANG_W-1:0]        byp_raw_ff;
   logic [swm_pkg::MAG_W-1:0]        mag_ff;
   logic [swm_pkg::ANG_W-1:0]        last_ff [N];
   logic [swm_pkg::ANG_W-1:0]        held_ff [N];
   logic signed [44:0]               mag_prod;
   logic signed [44:0]               mag_rnd;

   // Scale a module vector by 256 with sign extension.
   function automatic logic signed [swm_pkg::XY_W-1:0] XY_W_EXT(
      input logic signed [swm_pkg::VEC_W-1:0] v);
      return {v[swm_pkg::VEC_W-1], v, 8'b0};
   endfunction

   always_comb begin
      xi       = XY_W_EXT(vec_x);
      yi       = XY_W_EXT(vec_y);
      dx       = y_ff >>> cmd.iter_idx;
      dy       = x_ff >>> cmd.iter_idx;
      atan_v   = swm_pkg::atan_lookup(5'(cmd.iter_idx));
      mag_prod = x_ff * signed'({1'b0, 16'(swm_pkg::INV_GAIN_Q16)});
      mag_rnd  = mag_prod + 45'sd8388608;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vec) begin
         byp_ff     <= bypass;
         byp_raw_ff <= hold_ff ? held_ff[cmd.mod_idx] : '0;
         mag_ff     <= '0;
         if (vec_x < 0) begin
            x_ff <= -xi;
            y_ff <= -yi;
            z_ff <= 24'(swm_pkg::Z_HALF);
         end else begin
            x_ff <= xi;
            y_ff <= yi;
            z_ff <= '0;
         end
      end else if (cmd.iter) begin
         if (!y_ff[swm_pkg::XY_W-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_v;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_v;
         end
      end
      if (cmd.scale) begin
         mag_ff <= mag_rnd[43:24];
      end
   end

   // Finishing: raw angle, error wrap, flip, target and speed.
   logic signed [swm_pkg::Z_W-1:0]  z_pos, z_rnd;
   logic [17:0]                     ang_q;
   logic [swm_pkg::ANG_W-1:0]       raw, fb;
   logic signed [16:0]              err0, err;
   logic signed [17:0]              base, tgt;
   logic signed [20:0]              spd;

   always_comb begin
      z_pos = z_ff[swm_pkg::Z_W-1] ? z_ff + 24'(swm_pkg::Z_FULL) : z_ff;
      z_rnd = z_pos + 24'sd32;
      ang_q = z_rnd[23:6];
      if (ang_q >= 18'(swm_pkg::FULL_TURN)) begin
         ang_q = ang_q - 18'(swm_pkg::FULL_TURN);
      end
      raw  = byp_ff ? byp_raw_ff : ang_q[swm_pkg::ANG_W-1:0];
      fb   = fb_ff[cmd.mod_idx];
      err0 = signed'({2'b0, raw}) - signed'({2'b0, fb});
      if (err0 > 17'sd11520) begin
         err = err0 - 17'(swm_pkg::FULL_TURN);
      end else if (err0 < -17'sd11520) begin
         err = err0 + 17'(swm_pkg::FULL_TURN);
      end else begin
         err = err0;
      end
      base = signed'({3'b0, fb}) + 18'(err);
      if (err > 17'(swm_pkg::QUARTER_TURN)) begin
         tgt = base - 18'(swm_pkg::HALF_TURN);
         spd = signed'({1'b0, mag_ff});
      end else if (err < -17'(swm_pkg::QUARTER_TURN)) begin
         tgt = base + 18'(swm_pkg::HALF_TURN);
         spd = signed'({1'b0, mag_ff});
      end else begin
         tgt = base;
         spd = -signed'({1'b0, mag_ff});
      end
   end

   // Angle state and per-module working results.
   logic signed [swm_pkg::OUT_W-1:0] spd_ff [N];
   logic signed [swm_pkg::OUT_W-1:0] tgt_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            last_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else if (cmd.finish) begin
         if (!hold_ff) begin
            held_ff[cmd.mod_idx] <= last_ff[cmd.mod_idx];
         end
         last_ff[cmd.mod_idx] <= raw;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         spd_ff[cmd.mod_idx] <= swm_pkg::sat16(22'(spd));
         tgt_ff[cmd.mod_idx] <= swm_pkg::sat16(22'(tgt));
      end
   end

   // Output register.
   logic                         rsp_valid_ff;
   logic [swm_pkg::RSP_W-1:0]    rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= {tgt_ff[3], tgt_ff[2], tgt_ff[1], tgt_ff[0],
                         spd_ff[3], spd_ff[2], spd_ff[1], spd_ff[0]};
      end
   end

   assign status     = '{bypass: bypass, out_free: !rsp_valid_ff || rsp_tready};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for swerve_module_kinematics: directed and random velocity
// commands, a local kinematics predictor and a scoreboard. Depends on swm_pkg and the RTL.
module tb_top;

   localparam int IDLE_PCT   = 8;
   localparam int WATCHDOG   = 20000;
   localparam int RAND_ITEMS = 1680;

   typedef struct packed {
      logic [1:0]        op;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vw;
      logic [14:0]       fb0;
      logic [14:0]       fb1;
      logic [14:0]       fb2;
      logic [14:0]       fb3;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] spd0, spd1, spd2, spd3;
      logic signed [15:0] tgt0, tgt1, tgt2, tgt3;
   } wheel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [swm_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [swm_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [swm_pkg::CSR_W-1:0] csr_wdata = '0;

   swerve_module_kinematics dut (.*);

   // Predictor state and register copy.
   int unsigned p_sine, p_cosine, p_thr;
   int unsigned p_last[4];
   int unsigned p_held[4];

   req_item_type pending_cmds[$];
   wheel_type    expected_wheels[$];
   int     errors = 0;
   int     results_seen = 0;
   int     flips_seen = 0;
   int     holds_seen = 0;
   int     idle_cycles = 0;
   bit     calm = 1'b0;
   bit     hold_off = 1'b0;
   bit     driver_idle = 1'b1;

   // Handshake flags sampled at the rising edge.
   logic req_tready_q = 1'b0;
   logic acc_any;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint fl_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Vectoring: magnitude and raw angle of one module vector.
   task automatic vector_polar(input longint vx, input longint vy,
                               output longint mag, output int unsigned ang);
      longint x, y, z, dx, dy;
      x = vx * 256;
      y = vy * 256;
      z = 0;
      if (vx == 0 && vy == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = swm_pkg::Z_HALF;
      end
      for (int i = 0; i < swm_pkg::VECTOR_ITERATIONS && i < swm_pkg::ATAN_ENTRIES; i++) begin
         dx = fl_shift(y, i);
         dy = fl_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(swm_pkg::atan_lookup(i[4:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(swm_pkg::atan_lookup(i[4:0]));
         end
      end
      mag = fl_shift(x * swm_pkg::INV_GAIN_Q16 + (64'sd1 <<< 23), 24);
      if (z < 0) z += swm_pkg::Z_FULL;
      z = fl_shift(z + 32, 6);
      if (z >= swm_pkg::FULL_TURN) z -= swm_pkg::FULL_TURN;
      ang = 32'(z);
   endtask

   // Computes the wheel speeds and steering targets for one command.
   task automatic predict_wheels(input req_item_type c, output wheel_type w);
      longint vx, vy, vw, ox, oy, mag, fb, err, tgt, spd, sx, sy;
      longint thr;
      int unsigned raw;
      bit hold;
      logic [14:0] fbs[4];
      logic signed [15:0] spds[4], tgts[4];
      vx = c.vx; vy = c.vy; vw = c.vw;
      ox = fl_shift(vw * longint'(p_sine) + 4096, 13);
      oy = fl_shift(vw * longint'(p_cosine) + 4096, 13);
      thr = p_thr;
      fbs[0] = c.fb0; fbs[1] = c.fb1; fbs[2] = c.fb2; fbs[3] = c.fb3;
      hold = c.op == swm_pkg::OP_REMOTE && (vx < 0 ? -vx : vx) < thr &&
             (vy < 0 ? -vy : vy) < thr && (vw < 0 ? -vw : vw) < thr;
      if (hold) holds_seen++;
      for (int i = 0; i < 4; i++) begin
         mag = 0;
         raw = 0;
         fb = fbs[i];
         if (hold) begin
            raw = p_held[i];
         end else begin
            p_held[i] = p_last[i];
            if (c.op == swm_pkg::OP_REMOTE || c.op == swm_pkg::OP_DRIVE) begin
               sx = (i == 0 || i == 1) ? ox : -ox;
               sy = (i == 0 || i == 3) ? oy : -oy;
               vector_polar(vx + sx, vy + sy, mag, raw);
            end
         end
         p_last[i] = raw & 32'h7FFF;
         err = longint'(raw) - fb;
         while (err > swm_pkg::HALF_TURN) err -= swm_pkg::FULL_TURN;
         while (err < -swm_pkg::HALF_TURN) err += swm_pkg::FULL_TURN;
         if (err > swm_pkg::QUARTER_TURN) begin
            tgt = fb + err - swm_pkg::HALF_TURN; spd = mag; flips_seen++;
         end else if (err < -swm_pkg::QUARTER_TURN) begin
            tgt = fb + err + swm_pkg::HALF_TURN; spd = mag; flips_seen++;
         end else begin
            tgt = fb + err; spd = -mag;
         end
         spds[i] = 16'(clip16(spd));
         tgts[i] = 16'(clip16(tgt));
      end
      w = {spds[0], spds[1], spds[2], spds[3], tgts[0], tgts[1], tgts[2], tgts[3]};
   endtask

   function automatic logic [swm_pkg::REQ_W-1:0] pack_cmd(req_item_type c);
      logic [swm_pkg::REQ_W-1:0] d;
      d = '0;
      d[1:0] = c.op;   d[17:2] = c.vx;  d[33:18] = c.vy; d[49:34] = c.vw;
      d[64:50] = c.fb0; d[79:65] = c.fb1; d[94:80] = c.fb2; d[109:95] = c.fb3;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
   endtask

   // Driver: presents pending commands and predicts each accepted beat.
   always @(negedge clock) begin
      wheel_type w;
      if (!reset) begin
         if (req_tvalid && req_tready_q) begin
            predict_wheels(pending_cmds.pop_front(), w);
            expected_wheels.push_back(w);
         end
         if ((!req_tvalid || req_tready_q) ) begin
            if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata <= pack_cmd(pending_cmds[0]);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog over cycles with no accepted beat on either side.
   always @(posedge clock) begin
      req_tready_q <= req_tvalid && req_tready;
      acc_any = (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready);
      idle_cycles <= acc_any ? 0 : idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("watchdog expired with %0d results outstanding", expected_wheels.size());
         $display("swerve_module_kinematics test failed");
         $finish;
      end
   end

   // Monitor: compares each result beat with the oldest prediction.
   always @(posedge clock) begin
      wheel_type w;
      logic signed [15:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_wheels.size() == 0) begin
            report_mismatch("unexpected result beat", 0, 0);
         end else begin
            w = expected_wheels.pop_front();
            for (int i = 0; i < 8; i++) begin
               got = rsp_tdata[16*i +: 16];
               if (got !== w[16*(7-i) +: 16])
                  report_mismatch(i < 4 ? $sformatf("drive_speed_%0d", i)
                                        : $sformatf("steer_target_%0d", i - 4),
                                  got, $signed(w[16*(7-i) +: 16]));
            end
         end
      end
   end

   function automatic req_item_type random_cmd();
      req_item_type c;
      int r;
      c.op = $urandom_range(99) < 45 ? swm_pkg::OP_REMOTE :
             ($urandom_range(99) < 85 ? swm_pkg::OP_DRIVE : 2'($urandom_range(3)));
      r = $urandom_range(9);
      if (r < 2) begin
         c.vx = 16'($urandom); c.vy = 16'($urandom); c.vw = 16'($urandom);
      end else if (r < 4) begin
         // Small commands around the hold window.
         c.vx = 16'($signed(16'($urandom_range(1600))) - 800);
         c.vy = 16'($signed(16'($urandom_range(1600))) - 800);
         c.vw = 16'($signed(16'($urandom_range(1600))) - 800);
      end else begin
         c.vx = 16'($signed(16'($urandom_range(16384))) - 8192);
         c.vy = 16'($signed(16'($urandom_range(16384))) - 8192);
         c.vw = 16'($signed(16'($urandom_range(16384))) - 8192);
      end
      if ($urandom_range(30) == 0) begin
         c.fb0 = 15'($urandom); c.fb1 = 15'($urandom);
         c.fb2 = 15'($urandom); c.fb3 = 15'($urandom);
      end else begin
         c.fb0 = 15'($urandom_range(23039)); c.fb1 = 15'($urandom_range(23039));
         c.fb2 = 15'($urandom_range(23039)); c.fb3 = 15'($urandom_range(23039));
      end
      return c;
   endfunction

   function automatic req_item_type mk(logic [1:0] op, int vx, int vy, int vw, int fb);
      req_item_type c;
      c.op = op; c.vx = 16'(vx); c.vy = 16'(vy); c.vw = 16'(vw);
      c.fb0 = 15'(fb); c.fb1 = 15'(fb); c.fb2 = 15'(fb); c.fb3 = 15'(fb);
      return c;
   endfunction

   task automatic drain();
      wait (pending_cmds.size() == 0 && expected_wheels.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= swm_pkg::CSR_W'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == swm_pkg::REG_MOUNT_SINE) p_sine = val;
      else if (idx == swm_pkg::REG_MOUNT_COSINE) p_cosine = val;
      else p_thr = val;
   endtask

   // Stimulus sequence.
   initial begin
      int unsigned sines[4] = '{8192, 0, 5793, 3000};
      int unsigned coss[4]  = '{0, 8192, 5793, 7000};
      int unsigned thrs[4]  = '{0, 8192, 819, 2000};
      p_sine = 5793; p_cosine = 5793; p_thr = 819;
      for (int i = 0; i < 4; i++) begin
         p_last[i] = 0; p_held[i] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every opcode, field extremes, hold, flip and out-of-range feedback.
      pending_cmds.push_back(mk(swm_pkg::OP_STOP, 1000, 2000, 3000, 100));
      pending_cmds.push_back(mk(swm_pkg::OP_SPARE, -32768, 32767, 0, 23039));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 0, 0, 0, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 32767, 32767, 32767, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, -32768, -32768, -32768, 23039));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, -32768, 0, 0, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 0, -32768, 0, 11520));
      pending_cmds.push_back(mk(swm_pkg::OP_REMOTE, 4000, 4000, 0, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_REMOTE, 10, -10, 5, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_REMOTE, 818, -818, 818, 20000));
      pending_cmds.push_back(mk(swm_pkg::OP_REMOTE, 819, 0, 0, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, -4000, 100, 0, 0));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 4000, 0, 0, 17000));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 4000, 0, 0, 32767));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 0, 4000, 2000, 5000));
      pending_cmds.push_back(mk(swm_pkg::OP_DRIVE, 0, 0, 8192, 12000));
      drain();

      // Random phases over register settings, with a calm stretch and pressure.
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(swm_pkg::REG_MOUNT_SINE, sines[ph]);
         write_reg(swm_pkg::REG_MOUNT_COSINE, coss[ph]);
         write_reg(swm_pkg::REG_HOLD_THRESHOLD, thrs[ph]);
         calm = (ph == 2);
         for (int n = 0; n < RAND_ITEMS / 4; n++) pending_cmds.push_back(random_cmd());
         if (ph == 1) begin
            // Receiver holds off while the sender keeps offering beats.
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end
      calm = 1'b0;

      $display("Covered %0d results, %0d flipped modules, %0d hold steps, four settings.",
               results_seen, flips_seen, holds_seen);
      if (errors == 0) begin
         $display("swerve_module_kinematics test passed");
      end else begin
         $display("swerve_module_kinematics test failed");
      end
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_dp.sv
hw/rtl/swerve_module_kinematics.sv
sim/tb_top.sv
